// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/kwm_pkg.sv =====
// types, constants and codes of the k-way run merger
`default_nettype none

package kwm_pkg;

    localparam int MAX_RUNS  = 16;
    localparam int KEY_W     = 32;
    localparam int RUN_W     = 4;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 5;
    localparam int RUN_SEL_W = $clog2(MAX_RUNS);
    localparam int LIVE_W    = $clog2(MAX_RUNS + 1);
    localparam int CMP_W     = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
    localparam int Q_DEPTH   = 2;
    localparam int QP_W      = $clog2(Q_DEPTH);
    localparam int QC_W      = $clog2(Q_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_KEY   = 2'd1;
    localparam logic [OP_W-1:0] OP_END   = 2'd2;

    localparam logic [STAT_W-1:0] ST_KEY  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERR  = 2'd2;

    localparam logic [CNT_W-1:0] RUNS_CFG_RESET = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [RUN_W-1:0]        run_index;
        logic signed [KEY_W-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [RUN_W-1:0]        source_run;
        logic [STAT_W-1:0]       status;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_KEY   = 2'd1,
        CMD_END   = 2'd2,
        CMD_BAD   = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               kind;
        logic [RUN_W-1:0]        run_index;
        logic signed [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

`default_nettype wire

// ===== hw/rtl/kwm_front.sv =====
// front end: accepts items, decodes the opcode and queues commands
`default_nettype none
`include "assert_macros.svh"

module kwm_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire kwm_pkg::t_in_item i_in_item,
    input  wire logic              i_pop,
    output kwm_pkg::t_q_head       o_head
);
    import kwm_pkg::*;

    t_cmd            r_q [Q_DEPTH];
    logic [QP_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0] r_count, n_count;
    logic            push;
    t_cmd            cmd_in;

    assign o_in_stall = (r_count == QC_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;

    always_comb begin
        cmd_in.run_index = i_in_item.run_index;
        cmd_in.key       = i_in_item.key_value;
        case (i_in_item.opcode)
            OP_START: cmd_in.kind = CMD_START;
            OP_KEY:   cmd_in.kind = CMD_KEY;
            OP_END:   cmd_in.kind = CMD_END;
            default:  cmd_in.kind = CMD_BAD;
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + QC_W'(push) - QC_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

    `ASSERT_CLK(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> (r_count != '0), "pop from empty queue")

endmodule

`default_nettype wire

// ===== hw/rtl/kwm_back.sv =====
// back end: run state, head keys, minimum scan and result register
`default_nettype none
`include "assert_macros.svh"

module kwm_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire kwm_pkg::t_q_head       i_head,
    output logic                        o_pop,
    input  wire logic                   i_cfg_we,
    input  wire logic [kwm_pkg::CNT_W-1:0] i_cfg_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output kwm_pkg::t_out_item          o_out_item
);
    import kwm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [MAX_RUNS-1:0]     r_run_live, n_run_live;
    logic [MAX_RUNS-1:0]     r_head_valid, n_head_valid;
    logic [KEY_W-1:0]        r_head_key [MAX_RUNS];
    logic [CNT_W-1:0]        r_runs_cfg;
    logic [RUN_SEL_W-1:0]    r_scan, n_scan;
    logic [RUN_SEL_W-1:0]    r_best, n_best;
    logic [KEY_W-1:0]        r_best_key, n_best_key;
    logic                    r_found, n_found;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_item, n_out_item;

    logic                    slot_free;
    logic                    usable;
    logic                    key_we;
    logic [RUN_SEL_W-1:0]    sel;
    logic [CMP_W-1:0]        eff;
    logic [MAX_RUNS-1:0]     start_live;
    logic [KEY_W-1:0]        scan_key;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign sel       = RUN_SEL_W'(i_head.cmd.run_index);
    assign scan_key  = r_head_key[r_scan];
    assign o_pop     = (r_state == S_IDLE) && i_head.valid && slot_free;

    assign usable = (i_head.cmd.kind != CMD_BAD)
                 && ({1'b0, i_head.cmd.run_index} < (RUN_W + 1)'(MAX_RUNS))
                 && r_run_live[sel] && !r_head_valid[sel];

    always_comb begin
        if (r_runs_cfg == '0) begin
            eff = CMP_W'(1);
        end else if (CMP_W'(r_runs_cfg) > CMP_W'(MAX_RUNS)) begin
            eff = CMP_W'(MAX_RUNS);
        end else begin
            eff = CMP_W'(r_runs_cfg);
        end
        for (int i = 0; i < MAX_RUNS; i++) begin
            start_live[i] = (CMP_W'(i) < eff);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_run_live   = r_run_live;
        n_head_valid = r_head_valid;
        n_scan       = r_scan;
        n_best       = r_best;
        n_best_key   = r_best_key;
        n_found      = r_found;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_item   = r_out_item;
        key_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    if (i_head.cmd.kind == CMD_START) begin
                        n_head_valid = '0;
                        n_run_live   = start_live;
                    end else if (!usable) begin
                        n_out_valid           = 1'b1;
                        n_out_item.out_key    = '0;
                        n_out_item.source_run = i_head.cmd.run_index;
                        n_out_item.status     = ST_ERR;
                    end else if (i_head.cmd.kind == CMD_KEY) begin
                        key_we            = 1'b1;
                        n_head_valid[sel] = 1'b1;
                        if ((n_head_valid & r_run_live) == r_run_live) begin
                            n_state = S_SCAN;
                            n_scan  = '0;
                            n_found = 1'b0;
                        end
                    end else begin
                        n_run_live[sel] = 1'b0;
                        if (n_run_live == '0) begin
                            n_head_valid          = '0;
                            n_out_valid           = 1'b1;
                            n_out_item.out_key    = '0;
                            n_out_item.source_run = i_head.cmd.run_index;
                            n_out_item.status     = ST_DONE;
                        end else if ((r_head_valid & n_run_live) == n_run_live) begin
                            n_state = S_SCAN;
                            n_scan  = '0;
                            n_found = 1'b0;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_head_valid[r_scan]
                    && (!r_found || ($signed(scan_key) <= $signed(r_best_key)))) begin
                    n_best     = r_scan;
                    n_best_key = scan_key;
                    n_found    = 1'b1;
                end
                if (r_scan == RUN_SEL_W'(MAX_RUNS - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_head_valid[r_best]  = 1'b0;
                    n_out_valid           = 1'b1;
                    n_out_item.out_key    = r_best_key;
                    n_out_item.source_run = RUN_W'(r_best);
                    n_out_item.status     = ST_KEY;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_live   <= '0;
            r_head_valid <= '0;
            r_runs_cfg   <= RUNS_CFG_RESET;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run_live   <= n_run_live;
            r_head_valid <= n_head_valid;
            r_found      <= n_found;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_runs_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_best     <= n_best;
        r_best_key <= n_best_key;
        r_out_item <= n_out_item;
        if (key_we) begin
            r_head_key[sel] <= i_head.cmd.key;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `ASSERT_NEVER(a_head_in_live, i_clk, i_rst_n, (r_head_valid & ~r_run_live) != '0, "dead head")
    `ASSERT_CLK(a_scan_live, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_run_live != '0), "no live run")
    `ASSERT_CLK(a_emit_valid, i_clk, i_rst_n, (r_state == S_EMIT) |-> r_head_valid[r_best], "no head")

endmodule

`default_nettype wire

// ===== hw/rtl/kway_run_merger_top.sv =====
// top level of the k-way run merger
//
// channel   direction  handshake                payload
// in        input      i_in_valid/o_in_stall    t_in_item (opcode, run_index, key_value)
// out       output     o_out_valid/i_out_stall  t_out_item (out_key, source_run, status)
// cfg       input      i_cfg_valid/o_cfg_ready  number of runs, 5 bits
//
// an item is registered in the front queue, then popped by the back end when it is idle and the result slot is free
// a key or an end that leaves every live head full starts a scan of one head per cycle:
// the pop, then the scan over all head slots, then the emit, which waits for a free result slot
// the front queue holds two items, so input can be accepted while the back end works, until the queue is full
// output stall holds the result register and, only while it holds a result, blocks pops and the emit
// synchronous active-low reset clears run state; the run count register resets to 16
`default_nettype none

module kway_run_merger_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire kwm_pkg::t_in_item         i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output kwm_pkg::t_out_item             o_out_item,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [kwm_pkg::CNT_W-1:0] i_cfg_data
);
    import kwm_pkg::*;

    t_q_head head;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    kwm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_pop      (pop),
        .o_head     (head)
    );

    kwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== tb/kwm_merge_checker.sv =====
// checker for the k-way run merger: predicts every result and compares the output channel
`default_nettype none

module kwm_merge_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire kwm_pkg::t_in_item         i_in_item,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire kwm_pkg::t_out_item        i_out_item,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      i_cfg_ready,
    input  wire logic [kwm_pkg::CNT_W-1:0] i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;

    logic signed [KEY_W-1:0] head_key [MAX_RUNS];
    logic [MAX_RUNS-1:0]     head_full;
    logic [MAX_RUNS-1:0]     live_runs;
    logic [CNT_W-1:0]        runs_cfg;
    t_out_item               pending_results [$];
    int                      mismatch_count = 0;

    function automatic t_out_item make_result(logic signed [KEY_W-1:0] key, int run,
                                              logic [STAT_W-1:0] status);
        t_out_item res;
        res.out_key    = key;
        res.source_run = RUN_W'(run);
        res.status     = status;
        return res;
    endfunction

    // pops the smallest head once every live run holds one, ties to the highest run
    function automatic void emit_smallest_head();
        int best;
        logic found;
        best  = 0;
        found = 1'b0;
        if (live_runs == '0 || (head_full & live_runs) != live_runs) return;
        for (int r = 0; r < MAX_RUNS; r++) begin
            if (head_full[r] && (!found || head_key[r] <= head_key[best])) begin
                best  = r;
                found = 1'b1;
            end
        end
        if (found) begin
            head_full[best] = 1'b0;
            pending_results.push_back(make_result(head_key[best], best, ST_KEY));
        end
    endfunction

    function automatic void predict_merge_step(t_in_item it);
        int unsigned n;
        int idx;
        logic usable;
        idx = int'(it.run_index);
        if (it.opcode == OP_START) begin
            n = 32'(runs_cfg);
            if (n == 0) n = 1;
            if (n > MAX_RUNS) n = MAX_RUNS;
            head_full = '0;
            live_runs = '0;
            for (int r = 0; r < n; r++) live_runs[r] = 1'b1;
            return;
        end
        usable = (it.opcode == OP_KEY || it.opcode == OP_END) && live_runs[idx] &&
                 !head_full[idx];
        if (!usable) begin
            pending_results.push_back(make_result('0, idx, ST_ERR));
        end else if (it.opcode == OP_KEY) begin
            head_key[idx]  = it.key_value;
            head_full[idx] = 1'b1;
            emit_smallest_head();
        end else begin
            live_runs[idx] = 1'b0;
            if (live_runs == '0) begin
                head_full = '0;
                pending_results.push_back(make_result('0, idx, ST_DONE));
            end else begin
                emit_smallest_head();
            end
        end
    endfunction

    function automatic void note_mismatch(string what, t_out_item want, t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch, %s: expected key %0d run %0d status %0d, %s %0d %s %0d %s %0d",
                     $realtime, what, want.out_key, want.source_run, want.status,
                     "got key", got.out_key, "run", got.source_run, "status", got.status);
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            note_mismatch("no item expected", '0, got);
            return;
        end
        want = pending_results.pop_front();
        if (got.out_key !== want.out_key || got.source_run !== want.source_run ||
            got.status !== want.status)
            note_mismatch("wrong field", want, got);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_full = '0;
            live_runs = '0;
            runs_cfg  = RUNS_CFG_RESET;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_item);
            if (i_in_valid && !i_in_stall) predict_merge_step(i_in_item);
            if (i_cfg_valid && i_cfg_ready) runs_cfg = i_cfg_data;
        end
        o_mismatches <= mismatch_count;
        o_pending    <= pending_results.size();
    end

endmodule

`default_nettype wire

// ===== tb/kway_run_merger_top_test.sv =====
// testbench top for the k-way run merger: clock, reset, stimulus and verdict
`default_nettype none

module kway_run_merger_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;

    localparam int      DRAIN_CYCLES = 64;
    localparam int      QUIET_LIMIT  = 5000;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      ITEMS_PER_PHASE = 112;
    localparam longint  KEY_TOP = 64'sh7fff_ffff;
    localparam longint  KEY_BOTTOM = -64'sh8000_0000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    wire logic        in_stall;
    t_in_item         in_item;
    wire logic        out_valid;
    logic             out_stall;
    t_out_item        out_item;
    logic             cfg_valid;
    wire logic        cfg_ready;
    logic [CNT_W-1:0] cfg_data;
    int               chk_mismatches;
    int               chk_pending;
    int               items_sent = 0;
    int               quiet_cycles = 0;

    logic signed [KEY_W-1:0] gen_head [MAX_RUNS];
    logic [MAX_RUNS-1:0]     gen_has;
    logic [MAX_RUNS-1:0]     gen_live;
    logic [MAX_RUNS-1:0]     gen_started;
    longint                  last_key [MAX_RUNS];
    int                      keys_left [MAX_RUNS];
    logic                    narrow_keys;

    kway_run_merger_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    kwm_merge_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (chk_mismatches),
        .o_pending    (chk_pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // no idling on either side through one stretch of the random part
    function automatic logic idle_enabled();
        return !(items_sent >= 650 && items_sent < 850);
    endfunction

    initial begin : receiver
        logic held;
        int hold_left;
        held      = 1'b0;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && items_sent >= 520) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = idle_enabled() && ($urandom_range(99) < 8);
            end
        end
    end

    function automatic t_in_item mk_item(logic [OP_W-1:0] op, int run,
                                         logic signed [KEY_W-1:0] key);
        t_in_item it;
        it.opcode    = op;
        it.run_index = RUN_W'(run);
        it.key_value = key;
        return it;
    endfunction

    function automatic int unsigned clamp_runs(logic [CNT_W-1:0] c);
        if (c == 0) return 1;
        if (c > MAX_RUNS) return MAX_RUNS;
        return 32'(c);
    endfunction

    task automatic push_item(t_in_item it);
        int gap;
        gap = (idle_enabled() && $urandom_range(99) < 8) ? $urandom_range(5, 1) : 0;
        @(negedge clk);
        repeat (gap) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // waits until the block is idle, then writes the run count register
    task automatic write_count(logic [CNT_W-1:0] value);
        @(negedge clk);
        in_valid = 1'b0;
        while (chk_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // an item the block must reject, never one that fills an empty live head
    task automatic send_noise();
        t_in_item it;
        it.opcode    = OP_W'($urandom_range(3, 1));
        it.run_index = RUN_W'($urandom_range(MAX_RUNS - 1));
        it.key_value = $urandom;
        if ((it.opcode == OP_KEY || it.opcode == OP_END) &&
            gen_live[it.run_index] && !gen_has[it.run_index])
            it.opcode = CMD_BAD;
        push_item(it);
    endtask

    task automatic feed_run(int r);
        if ($urandom_range(99) < 6) send_noise();
        if (keys_left[r] > 0) begin
            keys_left[r]--;
            if (!gen_started[r]) begin
                gen_started[r] = 1'b1;
            end else if ($urandom_range(19) == 0) begin
                last_key[r] = KEY_TOP;
            end else begin
                last_key[r] = last_key[r] +
                              (narrow_keys ? longint'($urandom_range(2))
                                           : longint'($urandom_range(1 << 26)));
                if (last_key[r] > KEY_TOP) last_key[r] = KEY_TOP;
            end
            gen_head[r] = KEY_W'(last_key[r]);
            gen_has[r]  = 1'b1;
            push_item(mk_item(OP_KEY, r, gen_head[r]));
        end else begin
            gen_live[r] = 1'b0;
            push_item(mk_item(OP_END, r, $urandom));
        end
    endtask

    // one well-formed merge over n runs, now and then abandoned midway
    task automatic run_merge(int unsigned n);
        int order [MAX_RUNS];
        int j;
        int tmp;
        int best;
        narrow_keys = ($urandom_range(2) == 0);
        gen_has     = '0;
        gen_started = '0;
        gen_live    = '0;
        for (int r = 0; r < n; r++) begin
            gen_live[r]  = 1'b1;
            order[r]     = r;
            keys_left[r] = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
            if (narrow_keys)
                last_key[r] = longint'($urandom_range(16)) - 8;
            else if ($urandom_range(9) == 0)
                last_key[r] = KEY_BOTTOM;
            else
                last_key[r] = longint'($signed($urandom));
        end
        push_item(mk_item(OP_START, $urandom_range(MAX_RUNS - 1), $urandom));
        for (int i = n - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < n; i++) feed_run(order[i]);
        while (gen_live != '0) begin
            if ($urandom_range(99) == 0) return;
            best = -1;
            for (int r = 0; r < MAX_RUNS; r++) begin
                if (gen_has[r] && (best < 0 || gen_head[r] <= gen_head[best])) best = r;
            end
            gen_has[best] = 1'b0;
            feed_run(best);
        end
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] phase_counts [8];
        int target;
        phase_counts = '{5'd16, 5'd1, 5'd0, 5'd7, 5'd31, 5'd2, 5'd17, 5'd12};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        gen_has   = '0;
        gen_live  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // outside any merge
        push_item(mk_item(OP_END, 5, 32'sd0));
        push_item(mk_item(CMD_BAD, 0, -32'sd1));
        write_count(5'd2);
        push_item(mk_item(OP_START, 0, 32'sd0));
        push_item(mk_item(OP_KEY, 0, 32'sh8000_0000));
        push_item(mk_item(OP_KEY, 1, 32'sh7fff_ffff));
        push_item(mk_item(OP_KEY, 0, 32'sh7fff_ffff));
        // head already full, then a run beyond the count
        push_item(mk_item(OP_KEY, 0, 32'sd1));
        push_item(mk_item(OP_KEY, 3, 32'sd1));
        push_item(mk_item(OP_END, 1, 32'sd0));
        push_item(mk_item(OP_END, 0, 32'sd0));
        push_item(mk_item(OP_KEY, 0, 32'sd3));
        push_item(mk_item(CMD_BAD, 15, 32'sh7fff_ffff));
        // count written mid-merge only counts from the next start
        push_item(mk_item(OP_START, 15, -32'sd1));
        write_count(5'd3);
        push_item(mk_item(OP_KEY, 2, 32'sd9));
        push_item(mk_item(OP_END, 0, 32'sd0));
        push_item(mk_item(OP_END, 1, 32'sd0));
        push_item(mk_item(OP_START, 0, 32'sd0));
        push_item(mk_item(OP_KEY, 2, -32'sd1));
        push_item(mk_item(OP_END, 2, 32'sd0));
        push_item(mk_item(OP_END, 0, 32'sd0));
        push_item(mk_item(OP_END, 1, 32'sd0));
        push_item(mk_item(OP_END, 2, 32'sd0));

        foreach (phase_counts[p]) begin
            write_count(phase_counts[p]);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                run_merge(clamp_runs(phase_counts[p]));
                if ($urandom_range(9) == 0) send_noise();
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (chk_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk_mismatches == 0 && chk_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== kway_run_merger_top.f =====
+incdir+hw/rtl
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_front.sv
hw/rtl/kwm_back.sv
hw/rtl/kway_run_merger_top.sv
tb/kwm_merge_checker.sv
tb/kway_run_merger_top_test.sv
